>>> rtl/nbg_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_pkg
// Shared constants, codes and saturating helpers for the gravity step block.
// ----------------------------------------------------------------------------
package nbg_pkg;

    localparam int NBG_MAX_POINTS = 64;

    localparam int DIV_NW = 64;
    localparam int DIV_DW = 50;
    localparam int SQRT_W = 64;
    localparam int ROOT_W = 32;

    localparam logic [1:0] CMD_LOAD = 2'd0;
    localparam logic [1:0] CMD_STEP = 2'd1;
    localparam logic [1:0] CMD_READ = 2'd2;

    localparam logic [1:0] REG_G_CONST  = 2'd0;
    localparam logic [1:0] REG_MIN_DIST = 2'd1;
    localparam logic [1:0] REG_MASS     = 2'd2;
    localparam logic [1:0] REG_COUNT    = 2'd3;

    function automatic logic signed [49:0] sx50(input logic [31:0] a);
        return $signed({{18{a[31]}}, a});
    endfunction

    function automatic logic [31:0] sat32(input logic signed [49:0] v);
        logic [31:0] r;
        if (v > 50'sd2147483647)
            r = 32'h7FFF_FFFF;
        else if (v < -50'sd2147483648)
            r = 32'h8000_0000;
        else
            r = v[31:0];
        return r;
    endfunction

    function automatic logic [31:0] sat_q16(input logic [63:0] p);
        return (|p[63:48]) ? 32'hFFFF_FFFF : p[47:16];
    endfunction

endpackage

>>> rtl/nbody_gravity_step.sv
`timescale 1ns / 1ps
// Load and unknown commands return their word in the cycle after acceptance, a read
// after passing ST_READ. A step computes each pair within range on the shared divider and
// square root unit, skips the other pairs, then updates each point on the divider;
// one command is in the block at a time. After reset a clearing pass over every store
// entry zeroes velocities and forces before the first word is accepted; configuration
// writes are taken throughout.
// ----------------------------------------------------------------------------
// nbody_gravity_step
// Direct-sum gravity step over a point store, run by a sequencer around one
// shared multiplier, divider and square root unit.
// ----------------------------------------------------------------------------
module nbody_gravity_step import nbg_pkg::*; #(
    parameter int MAX_POINTS = NBG_MAX_POINTS
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         command,
    input  logic [5:0]         point_index,
    input  logic signed [31:0] in_pos_x,
    input  logic signed [31:0] in_pos_y,
    input  logic signed [31:0] in_pos_z,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [5:0]         out_index,
    output logic signed [31:0] out_pos_x,
    output logic signed [31:0] out_pos_y,
    output logic signed [31:0] out_pos_z,
    output logic signed [31:0] out_vel_x,
    output logic signed [31:0] out_vel_y,
    output logic signed [31:0] out_vel_z,
    output logic               step_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready
);

    localparam int IW = $clog2(MAX_POINTS);
    localparam int CW = $clog2(MAX_POINTS + 1);

    typedef enum logic [4:0] {
        ST_CLEAR, ST_IDLE, ST_READ, ST_GM_A, ST_GM_B, ST_GM_C,
        ST_I_START, ST_I_LOAD, ST_J_RD, ST_J_LOAD, ST_SQ_MUL, ST_SQ_ACC,
        ST_R2_CHK, ST_SQRT_WAIT, ST_FDIV_GO, ST_FDIV_WAIT, ST_C_MUL, ST_C_GO,
        ST_C_WAIT, ST_J_WR, ST_J_NEXT, ST_I_WR, ST_U_RD, ST_U_LOAD, ST_U_GO,
        ST_U_WAIT, ST_U_WR, ST_DONE
    } state_t;

    state_t      state_reg;
    logic [31:0] g_const_reg;
    logic [31:0] min_dist_reg;
    logic [31:0] mass_reg;
    logic [6:0]  count_reg;

    logic [CW-1:0] i_reg;
    logic [CW-1:0] j_reg;
    logic [CW-1:0] n_reg;
    logic [1:0]    ax_reg;
    logic [95:0]   pi_reg;
    logic [95:0]   fi_reg;
    logic [95:0]   fj_reg;
    logic [95:0]   vi_reg;
    logic [95:0]   dabs_reg;
    logic [2:0]    dneg_reg;
    logic [49:0]   r2_reg;
    logic [32:0]   r_reg;
    logic [31:0]   gmm_reg;
    logic [31:0]   fmag_reg;
    logic [63:0]   mul_p_reg;
    logic [5:0]    idx_reg;
    logic          hit_reg;

    logic          out_valid_reg;
    logic [5:0]    out_index_reg;
    logic [95:0]   out_pos_reg;
    logic [95:0]   out_vel_reg;
    logic          step_done_reg;

    logic [95:0]   pos_rdata;
    logic [95:0]   vel_rdata;
    logic [95:0]   frc_rdata;
    logic [IW-1:0] raddr;
    logic [IW-1:0] pos_waddr;
    logic [IW-1:0] frc_waddr;
    logic          pos_we;
    logic          vel_we;
    logic          frc_we;
    logic [95:0]   pos_wdata;
    logic [95:0]   vel_wdata;
    logic [95:0]   frc_wdata;

    logic              in_accept;
    logic              idx_hit;
    logic [31:0]       mass_eff;
    logic [31:0]       mul_a;
    logic [31:0]       mul_b;
    logic              div_start;
    logic [DIV_NW-1:0] div_a;
    logic [DIV_DW-1:0] div_b;
    logic              div_busy;
    logic              div_done;
    logic [DIV_NW-1:0] div_quo;
    logic              sqrt_start;
    logic [SQRT_W-1:0] sqrt_a;
    logic              sqrt_busy;
    logic              sqrt_done;
    logic [ROOT_W-1:0] sqrt_root;

    logic signed [32:0] d_new [3];
    logic [95:0]        dabs_new;
    logic [2:0]         dneg_new;
    logic [95:0]        pos_new;
    logic [31:0]        cur_dabs;
    logic               cur_dneg;
    logic [31:0]        cur_fi;
    logic [31:0]        cur_fj;
    logic [31:0]        cur_vi;
    logic [31:0]        cur_fabs;
    logic [30:0]        c_mag;
    logic signed [49:0] c_ext;
    logic signed [49:0] q_ext;
    logic [31:0]        fi_sum;
    logic [31:0]        fj_sum;
    logic [31:0]        vi_sum;
    logic               big;
    logic               skip;

    // Configuration registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            g_const_reg  <= 32'd65536;
            min_dist_reg <= 32'd655;
            mass_reg     <= 32'd65536;
            count_reg    <= 7'd64;
        end
        else if (psel && penable && pwrite)
        begin
            case (paddr[3:2])
                REG_G_CONST:  g_const_reg  <= pwdata;
                REG_MIN_DIST: min_dist_reg <= pwdata;
                REG_MASS:     mass_reg     <= pwdata;
                REG_COUNT:    count_reg    <= pwdata[6:0];
                default:      ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[3:2])
            REG_G_CONST:  prdata = g_const_reg;
            REG_MIN_DIST: prdata = min_dist_reg;
            REG_MASS:     prdata = mass_reg;
            REG_COUNT:    prdata = {25'd0, count_reg};
            default:      prdata = '0;
        endcase
    end

    assign pready = 1'b1;

    assign in_stall  = (state_reg != ST_IDLE) || out_valid_reg;
    assign in_accept = in_valid && !in_stall;
    assign idx_hit   = ({26'd0, point_index} < 32'(MAX_POINTS));
    assign mass_eff  = (mass_reg == 32'd0) ? 32'd1 : mass_reg;

    // Axis datapath.
    always_comb
    begin
        for (int k = 0; k < 3; k++)
        begin
            d_new[k] = $signed({pos_rdata[32*k+31], pos_rdata[32*k +: 32]})
                     - $signed({pi_reg[32*k+31], pi_reg[32*k +: 32]});
            dneg_new[k] = d_new[k][32];
            dabs_new[32*k +: 32] = d_new[k][32] ? 32'(-d_new[k]) : d_new[k][31:0];
            pos_new[32*k +: 32] = sat32(sx50(pi_reg[32*k +: 32])
                                      + sx50(vi_reg[32*k +: 32]));
        end
        cur_dabs = dabs_reg[32*ax_reg +: 32];
        cur_dneg = dneg_reg[ax_reg];
        cur_fi   = fi_reg[32*ax_reg +: 32];
        cur_fj   = fj_reg[32*ax_reg +: 32];
        cur_vi   = vi_reg[32*ax_reg +: 32];
        cur_fabs = cur_fi[31] ? (~cur_fi + 32'd1) : cur_fi;
        c_mag    = (|div_quo[63:31]) ? 31'h7FFF_FFFF : div_quo[30:0];
        c_ext    = cur_dneg ? -$signed({19'd0, c_mag}) : $signed({19'd0, c_mag});
        q_ext    = cur_fi[31] ? -$signed({2'd0, div_quo[47:0]})
                              : $signed({2'd0, div_quo[47:0]});
        fi_sum   = sat32(sx50(cur_fi) + c_ext);
        fj_sum   = sat32(sx50(cur_fj) - c_ext);
        vi_sum   = sat32(sx50(cur_vi) + q_ext);
        big      = |r2_reg[49:48];
        skip     = (r2_reg == 50'd0) || (r2_reg < {18'd0, min_dist_reg});
    end

    // Shared multiplier operands.
    always_comb
    begin
        case (state_reg)
            ST_GM_A:
            begin
                mul_a = g_const_reg;
                mul_b = mass_eff;
            end
            ST_GM_B:
            begin
                mul_a = sat_q16(mul_p_reg);
                mul_b = mass_eff;
            end
            ST_SQ_MUL:
            begin
                mul_a = cur_dabs;
                mul_b = cur_dabs;
            end
            ST_C_MUL:
            begin
                mul_a = fmag_reg;
                mul_b = cur_dabs;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        mul_p_reg <= {32'd0, mul_a} * {32'd0, mul_b};
    end

    // Divider and square root operands.
    always_comb
    begin
        div_start = (state_reg == ST_FDIV_GO) || (state_reg == ST_C_GO)
                 || (state_reg == ST_U_GO);
        case (state_reg)
            ST_FDIV_GO:
            begin
                div_a = {16'd0, gmm_reg, 16'd0};
                div_b = r2_reg;
            end
            ST_C_GO:
            begin
                div_a = mul_p_reg;
                div_b = {17'd0, r_reg};
            end
            default:
            begin
                div_a = {16'd0, cur_fabs, 16'd0};
                div_b = {18'd0, mass_eff};
            end
        endcase
        sqrt_start = (state_reg == ST_R2_CHK) && !skip;
        sqrt_a     = big ? {14'd0, r2_reg} : {r2_reg[47:0], 16'd0};
    end

    // Store access.
    always_comb
    begin
        raddr     = i_reg[IW-1:0];
        pos_waddr = i_reg[IW-1:0];
        frc_waddr = i_reg[IW-1:0];
        pos_we    = 1'b0;
        vel_we    = 1'b0;
        frc_we    = 1'b0;
        pos_wdata = pos_new;
        vel_wdata = vi_reg;
        frc_wdata = '0;
        case (state_reg)
            ST_CLEAR:
            begin
                vel_we    = 1'b1;
                frc_we    = 1'b1;
                vel_wdata = '0;
            end
            ST_IDLE:
            begin
                raddr     = IW'(point_index);
                pos_waddr = IW'(point_index);
                if (in_accept && (command == CMD_LOAD) && idx_hit)
                begin
                    pos_we    = 1'b1;
                    vel_we    = 1'b1;
                    pos_wdata = {in_pos_z, in_pos_y, in_pos_x};
                    vel_wdata = '0;
                end
            end
            ST_J_RD:
            begin
                raddr = j_reg[IW-1:0];
            end
            ST_J_WR:
            begin
                frc_we    = 1'b1;
                frc_waddr = j_reg[IW-1:0];
                frc_wdata = fj_reg;
            end
            ST_I_WR:
            begin
                frc_we    = 1'b1;
                frc_wdata = fi_reg;
            end
            ST_U_WR:
            begin
                pos_we = 1'b1;
                vel_we = 1'b1;
                frc_we = 1'b1;
            end
            default: ;
        endcase
    end

    // Sequencer.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            ax_reg        <= '0;
            pi_reg        <= '0;
            fi_reg        <= '0;
            fj_reg        <= '0;
            vi_reg        <= '0;
            dabs_reg      <= '0;
            dneg_reg      <= '0;
            r2_reg        <= '0;
            r_reg         <= '0;
            gmm_reg       <= '0;
            fmag_reg      <= '0;
            idx_reg       <= '0;
            hit_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            out_index_reg <= '0;
            out_pos_reg   <= '0;
            out_vel_reg   <= '0;
            step_done_reg <= 1'b0;
        end
        else
        begin
            if (out_valid_reg && !out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    if (i_reg == CW'(MAX_POINTS - 1))
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_IDLE;
                    end
                    else
                    begin
                        i_reg <= i_reg + 1'b1;
                    end
                end
                ST_IDLE:
                begin
                    if (in_accept)
                    begin
                        case (command)
                            CMD_LOAD:
                            begin
                                out_valid_reg <= 1'b1;
                                out_index_reg <= point_index;
                                out_pos_reg   <= idx_hit ? {in_pos_z, in_pos_y, in_pos_x}
                                                         : 96'd0;
                                out_vel_reg   <= '0;
                                step_done_reg <= 1'b0;
                            end
                            CMD_READ:
                            begin
                                idx_reg   <= point_index;
                                hit_reg   <= idx_hit;
                                state_reg <= ST_READ;
                            end
                            CMD_STEP:
                            begin
                                n_reg <= ({25'd0, count_reg} > 32'(MAX_POINTS))
                                       ? CW'(MAX_POINTS) : CW'(count_reg);
                                state_reg <= ST_GM_A;
                            end
                            default:
                            begin
                                out_valid_reg <= 1'b1;
                                out_index_reg <= '0;
                                out_pos_reg   <= '0;
                                out_vel_reg   <= '0;
                                step_done_reg <= 1'b0;
                            end
                        endcase
                    end
                end
                ST_READ:
                begin
                    out_valid_reg <= 1'b1;
                    out_index_reg <= idx_reg;
                    out_pos_reg   <= hit_reg ? pos_rdata : 96'd0;
                    out_vel_reg   <= hit_reg ? vel_rdata : 96'd0;
                    step_done_reg <= 1'b0;
                    state_reg     <= ST_IDLE;
                end
                ST_GM_A:
                begin
                    state_reg <= ST_GM_B;
                end
                ST_GM_B:
                begin
                    state_reg <= ST_GM_C;
                end
                ST_GM_C:
                begin
                    gmm_reg   <= sat_q16(mul_p_reg);
                    i_reg     <= '0;
                    state_reg <= ST_I_START;
                end
                ST_I_START:
                begin
                    if ((i_reg + 1'b1) >= n_reg)
                    begin
                        i_reg     <= '0;
                        state_reg <= ST_U_RD;
                    end
                    else
                    begin
                        state_reg <= ST_I_LOAD;
                    end
                end
                ST_I_LOAD:
                begin
                    pi_reg    <= pos_rdata;
                    fi_reg    <= frc_rdata;
                    j_reg     <= i_reg + 1'b1;
                    state_reg <= ST_J_RD;
                end
                ST_J_RD:
                begin
                    state_reg <= ST_J_LOAD;
                end
                ST_J_LOAD:
                begin
                    dabs_reg  <= dabs_new;
                    dneg_reg  <= dneg_new;
                    fj_reg    <= frc_rdata;
                    r2_reg    <= '0;
                    ax_reg    <= '0;
                    state_reg <= ST_SQ_MUL;
                end
                ST_SQ_MUL:
                begin
                    state_reg <= ST_SQ_ACC;
                end
                ST_SQ_ACC:
                begin
                    r2_reg <= r2_reg + {2'd0, mul_p_reg[63:16]};
                    if (ax_reg == 2'd2)
                    begin
                        ax_reg    <= '0;
                        state_reg <= ST_R2_CHK;
                    end
                    else
                    begin
                        ax_reg    <= ax_reg + 1'b1;
                        state_reg <= ST_SQ_MUL;
                    end
                end
                ST_R2_CHK:
                begin
                    state_reg <= skip ? ST_J_NEXT : ST_SQRT_WAIT;
                end
                ST_SQRT_WAIT:
                begin
                    if (sqrt_done)
                    begin
                        r_reg     <= big ? {sqrt_root[24:0], 8'd0} : {1'b0, sqrt_root};
                        state_reg <= ST_FDIV_GO;
                    end
                end
                ST_FDIV_GO:
                begin
                    state_reg <= ST_FDIV_WAIT;
                end
                ST_FDIV_WAIT:
                begin
                    if (div_done)
                    begin
                        fmag_reg  <= (|div_quo[63:32]) ? 32'hFFFF_FFFF : div_quo[31:0];
                        ax_reg    <= '0;
                        state_reg <= ST_C_MUL;
                    end
                end
                ST_C_MUL:
                begin
                    state_reg <= ST_C_GO;
                end
                ST_C_GO:
                begin
                    state_reg <= ST_C_WAIT;
                end
                ST_C_WAIT:
                begin
                    if (div_done)
                    begin
                        fi_reg[32*ax_reg +: 32] <= fi_sum;
                        fj_reg[32*ax_reg +: 32] <= fj_sum;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= ST_J_WR;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= ST_C_MUL;
                        end
                    end
                end
                ST_J_WR:
                begin
                    state_reg <= ST_J_NEXT;
                end
                ST_J_NEXT:
                begin
                    if ((j_reg + 1'b1) >= n_reg)
                    begin
                        state_reg <= ST_I_WR;
                    end
                    else
                    begin
                        j_reg     <= j_reg + 1'b1;
                        state_reg <= ST_J_RD;
                    end
                end
                ST_I_WR:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_I_START;
                end
                ST_U_RD:
                begin
                    state_reg <= (i_reg >= n_reg) ? ST_DONE : ST_U_LOAD;
                end
                ST_U_LOAD:
                begin
                    pi_reg    <= pos_rdata;
                    vi_reg    <= vel_rdata;
                    fi_reg    <= frc_rdata;
                    ax_reg    <= '0;
                    state_reg <= ST_U_GO;
                end
                ST_U_GO:
                begin
                    state_reg <= ST_U_WAIT;
                end
                ST_U_WAIT:
                begin
                    if (div_done)
                    begin
                        vi_reg[32*ax_reg +: 32] <= vi_sum;
                        if (ax_reg == 2'd2)
                        begin
                            state_reg <= ST_U_WR;
                        end
                        else
                        begin
                            ax_reg    <= ax_reg + 1'b1;
                            state_reg <= ST_U_GO;
                        end
                    end
                end
                ST_U_WR:
                begin
                    i_reg     <= i_reg + 1'b1;
                    state_reg <= ST_U_RD;
                end
                ST_DONE:
                begin
                    out_valid_reg <= 1'b1;
                    out_index_reg <= '0;
                    out_pos_reg   <= '0;
                    out_vel_reg   <= '0;
                    step_done_reg <= 1'b1;
                    state_reg     <= ST_IDLE;
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    nbg_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_pos_ram (
        .clk   (clk),
        .we    (pos_we),
        .waddr (pos_waddr),
        .wdata (pos_wdata),
        .raddr (raddr),
        .rdata (pos_rdata)
    );

    nbg_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_vel_ram (
        .clk   (clk),
        .we    (vel_we),
        .waddr (pos_waddr),
        .wdata (vel_wdata),
        .raddr (raddr),
        .rdata (vel_rdata)
    );

    nbg_ram #(.WIDTH(96), .DEPTH(MAX_POINTS)) u_frc_ram (
        .clk   (clk),
        .we    (frc_we),
        .waddr (frc_waddr),
        .wdata (frc_wdata),
        .raddr (raddr),
        .rdata (frc_rdata)
    );

    nbg_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_a),
        .divisor  (div_b),
        .busy     (div_busy),
        .done     (div_done),
        .quotient (div_quo)
    );

    nbg_sqrt u_sqrt (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (sqrt_start),
        .operand (sqrt_a),
        .busy    (sqrt_busy),
        .done    (sqrt_done),
        .root    (sqrt_root)
    );

    assign out_valid = out_valid_reg;
    assign out_index = out_index_reg;
    assign out_pos_x = $signed(out_pos_reg[31:0]);
    assign out_pos_y = $signed(out_pos_reg[63:32]);
    assign out_pos_z = $signed(out_pos_reg[95:64]);
    assign out_vel_x = $signed(out_vel_reg[31:0]);
    assign out_vel_y = $signed(out_vel_reg[63:32]);
    assign out_vel_z = $signed(out_vel_reg[95:64]);
    assign step_done = step_done_reg;

    a_div_free: assert property (@(posedge clk) disable iff (!rst_n)
        div_start |-> !div_busy)
        else $error("divider started while busy");

    a_sqrt_free: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_start |-> !sqrt_busy)
        else $error("square root started while busy");

    a_sqrt_owner: assert property (@(posedge clk) disable iff (!rst_n)
        sqrt_done |-> (state_reg == ST_SQRT_WAIT))
        else $error("square root finished outside its wait state");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_done |-> (state_reg == ST_FDIV_WAIT || state_reg == ST_C_WAIT
                   || state_reg == ST_U_WAIT))
        else $error("divider finished outside a wait state");

    a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_J_LOAD) |-> (j_reg > i_reg && j_reg < n_reg))
        else $error("pair indices out of order");

endmodule

>>> rtl/nbg_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_ram
// Generic simple dual-port RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module nbg_ram #(
    parameter int WIDTH = 96,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/nbg_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_div
// Restoring unsigned divider producing one quotient bit per cycle.
// ----------------------------------------------------------------------------
module nbg_div import nbg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [DIV_NW-1:0] dividend,
    input  logic [DIV_DW-1:0] divisor,
    output logic              busy,
    output logic              done,
    output logic [DIV_NW-1:0] quotient
);

    localparam int CNT_W = $clog2(DIV_NW);

    logic [DIV_NW-1:0] quo_reg;
    logic [DIV_DW-1:0] rem_reg;
    logic [DIV_DW-1:0] dvs_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_DW:0]   shifted;
    logic [DIV_DW:0]   diff;
    logic              fits;
    logic [DIV_DW-1:0] rem_next;
    logic [DIV_NW-1:0] quo_next;

    always_comb
    begin
        shifted  = {rem_reg, quo_reg[DIV_NW-1]};
        diff     = shifted - {1'b0, dvs_reg};
        fits     = (shifted >= {1'b0, dvs_reg});
        rem_next = fits ? diff[DIV_DW-1:0] : shifted[DIV_DW-1:0];
        quo_next = {quo_reg[DIV_NW-2:0], fits};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(DIV_NW - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            dvs_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= quo_next;
            rem_reg <= rem_next;
        end
    end

    assign busy     = busy_reg;
    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

>>> rtl/nbg_sqrt.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbg_sqrt
// Digit-by-digit integer square root, one root bit per cycle.
// ----------------------------------------------------------------------------
module nbg_sqrt import nbg_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              start,
    input  logic [SQRT_W-1:0] operand,
    output logic              busy,
    output logic              done,
    output logic [ROOT_W-1:0] root
);

    localparam int CNT_W = $clog2(ROOT_W);

    logic [SQRT_W-1:0] val_reg;
    logic [ROOT_W+1:0] rem_reg;
    logic [ROOT_W-1:0] root_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [ROOT_W+3:0] rs;
    logic [ROOT_W+3:0] trial;
    logic              fits;
    logic [ROOT_W+3:0] diff;

    always_comb
    begin
        rs    = {rem_reg, val_reg[SQRT_W-1:SQRT_W-2]};
        trial = {2'b00, root_reg, 2'b01};
        fits  = (rs >= trial);
        diff  = rs - trial;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
            if (cnt_reg == CNT_W'(ROOT_W - 1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            val_reg  <= operand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            val_reg  <= {val_reg[SQRT_W-3:0], 2'b00};
            rem_reg  <= fits ? diff[ROOT_W+1:0] : rs[ROOT_W+1:0];
            root_reg <= {root_reg[ROOT_W-2:0], fits};
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> dv/nbody_gravity_step_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_step_checker
// Watches the command, result and register channels of the gravity step
// block, predicts every result word from its own copy of the point store and
// compares each accepted result word with the oldest prediction.
// ----------------------------------------------------------------------------
module nbody_gravity_step_checker import nbg_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_stall,
    input  logic [1:0]         command,
    input  logic [5:0]         point_index,
    input  logic signed [31:0] in_pos_x,
    input  logic signed [31:0] in_pos_y,
    input  logic signed [31:0] in_pos_z,
    input  logic               out_valid,
    input  logic               out_stall,
    input  logic [5:0]         out_index,
    input  logic signed [31:0] out_pos_x,
    input  logic signed [31:0] out_pos_y,
    input  logic signed [31:0] out_pos_z,
    input  logic signed [31:0] out_vel_x,
    input  logic signed [31:0] out_vel_y,
    input  logic signed [31:0] out_vel_z,
    input  logic               step_done,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [3:0]         paddr,
    input  logic [31:0]        pwdata,
    input  logic               pready,
    output int                 fails,
    output int                 pending
);

    typedef struct {
        logic [5:0]         idx;
        logic signed [31:0] pos [3];
        logic signed [31:0] vel [3];
        logic               done;
    } point_word_t;

    logic [31:0] g_const, min_dist_sq, point_mass;
    logic [6:0]  point_count;
    logic signed [31:0] pos [3][NBG_MAX_POINTS];
    logic signed [31:0] vel [3][NBG_MAX_POINTS];
    logic signed [31:0] frc [3][NBG_MAX_POINTS];
    point_word_t expected_words [$];

    assign pending = expected_words.size();

    function automatic logic signed [31:0] sat_sum(logic signed [31:0] a, longint b);
        longint s;
        s = longint'(a) + b;
        if (s > 64'sd2147483647)
            return 32'sh7FFF_FFFF;
        if (s < -64'sd2147483648)
            return 32'sh8000_0000;
        return s[31:0];
    endfunction

    function automatic logic [63:0] int_root(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    function automatic logic [63:0] magnitude(longint d);
        return (d < 0) ? 64'(-d) : 64'(d);
    endfunction

    task automatic apply_pair(int i, int j, logic [63:0] gmm);
        longint      d [3];
        logic [63:0] r2, r, fmag, prod, c;
        longint      comp [3];
        r2 = 0;
        for (int a = 0; a < 3; a++)
        begin
            d[a] = longint'(pos[a][j]) - longint'(pos[a][i]);
            r2 = r2 + ((magnitude(d[a]) * magnitude(d[a])) >> 16);
        end
        if (r2 == 0 || r2 < {32'd0, min_dist_sq})
            return;
        if (r2 < (64'd1 << 48))
            r = int_root(r2 << 16);
        else
            r = int_root(r2) << 8;
        fmag = (gmm << 16) / r2;
        if (fmag > 64'hFFFF_FFFF)
            fmag = 64'hFFFF_FFFF;
        for (int a = 0; a < 3; a++)
        begin
            prod = fmag * magnitude(d[a]);
            c = prod / r;
            if (c > 64'h7FFF_FFFF)
                c = 64'h7FFF_FFFF;
            comp[a] = (d[a] < 0) ? -longint'(c) : longint'(c);
            frc[a][i] = sat_sum(frc[a][i], comp[a]);
            frc[a][j] = sat_sum(frc[a][j], -comp[a]);
        end
    endtask

    task automatic advance_system();
        int          n;
        logic [63:0] m, gm, gmm, q;
        longint      f;
        n = (point_count > NBG_MAX_POINTS) ? NBG_MAX_POINTS : int'(point_count);
        m = (point_mass == 0) ? 64'd1 : {32'd0, point_mass};
        gm = ({32'd0, g_const} * m) >> 16;
        if (gm > 64'hFFFF_FFFF)
            gm = 64'hFFFF_FFFF;
        gmm = (gm * m) >> 16;
        if (gmm > 64'hFFFF_FFFF)
            gmm = 64'hFFFF_FFFF;
        for (int i = 0; i < n; i++)
            for (int j = i + 1; j < n; j++)
                apply_pair(i, j, gmm);
        for (int i = 0; i < n; i++)
            for (int a = 0; a < 3; a++)
            begin
                f = longint'(frc[a][i]);
                q = (magnitude(f) << 16) / m;
                vel[a][i] = sat_sum(vel[a][i], (f < 0) ? -longint'(q) : longint'(q));
                pos[a][i] = sat_sum(pos[a][i], longint'(vel[a][i]));
            end
        for (int i = 0; i < NBG_MAX_POINTS; i++)
            for (int a = 0; a < 3; a++)
                frc[a][i] = 0;
    endtask

    task automatic predict_word();
        point_word_t w;
        w.idx = 0;
        w.done = 0;
        for (int a = 0; a < 3; a++)
        begin
            w.pos[a] = 0;
            w.vel[a] = 0;
        end
        if (command == CMD_STEP)
        begin
            advance_system();
            w.done = 1;
        end
        else if (command == CMD_LOAD || command == CMD_READ)
        begin
            w.idx = point_index;
            if (command == CMD_LOAD)
            begin
                pos[0][point_index] = in_pos_x;
                pos[1][point_index] = in_pos_y;
                pos[2][point_index] = in_pos_z;
                for (int a = 0; a < 3; a++)
                    vel[a][point_index] = 0;
            end
            for (int a = 0; a < 3; a++)
            begin
                w.pos[a] = pos[a][point_index];
                w.vel[a] = vel[a][point_index];
            end
        end
        expected_words.push_back(w);
    endtask

    task automatic compare_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (exp_v !== act_v)
        begin
            $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_v, act_v);
            fails++;
        end
    endtask

    task automatic check_word();
        point_word_t w;
        if (expected_words.size() == 0)
        begin
            $display("%0t: result word with none expected, index %0d", $time, out_index);
            fails++;
            return;
        end
        w = expected_words.pop_front();
        compare_field("out_index", 32'(w.idx), 32'(out_index));
        compare_field("out_pos_x", w.pos[0], out_pos_x);
        compare_field("out_pos_y", w.pos[1], out_pos_y);
        compare_field("out_pos_z", w.pos[2], out_pos_z);
        compare_field("out_vel_x", w.vel[0], out_vel_x);
        compare_field("out_vel_y", w.vel[1], out_vel_y);
        compare_field("out_vel_z", w.vel[2], out_vel_z);
        compare_field("step_done", 32'(w.done), 32'(step_done));
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fails = 0;
            g_const <= 32'd65536;
            min_dist_sq <= 32'd655;
            point_mass <= 32'd65536;
            point_count <= 7'd64;
            for (int i = 0; i < NBG_MAX_POINTS; i++)
                for (int a = 0; a < 3; a++)
                begin
                    pos[a][i] = 0;
                    vel[a][i] = 0;
                    frc[a][i] = 0;
                end
        end
        else
        begin
            if (psel && penable && pwrite && pready)
            begin
                case (paddr[3:2])
                    REG_G_CONST:  g_const <= pwdata;
                    REG_MIN_DIST: min_dist_sq <= pwdata;
                    REG_MASS:     point_mass <= pwdata;
                    REG_COUNT:    point_count <= pwdata[6:0];
                    default:      ;
                endcase
            end
            if (out_valid && !out_stall)
                check_word();
            if (in_valid && !in_stall)
                predict_word();
        end
    end

endmodule

>>> dv/nbody_gravity_step_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nbody_gravity_step_test
// Drives the gravity step block through a short directed sequence and then
// through phases of random loads, reads, steps and unknown commands under
// several register settings, with random gaps and result stalls; a checker beside
// the block predicts and compares every result word.
// ----------------------------------------------------------------------------
module nbody_gravity_step_test;
    import nbg_pkg::*;

    localparam int CYCLE_LIMIT = 6000000;
    localparam int PHASES = 8;

    logic               clk = 0;
    logic               rst_n = 0;
    logic               in_valid = 0;
    logic               in_stall;
    logic [1:0]         command = CMD_LOAD;
    logic [5:0]         point_index = 0;
    logic signed [31:0] in_pos_x = 0;
    logic signed [31:0] in_pos_y = 0;
    logic signed [31:0] in_pos_z = 0;
    logic               out_valid;
    logic               out_stall = 0;
    logic [5:0]         out_index;
    logic signed [31:0] out_pos_x, out_pos_y, out_pos_z;
    logic signed [31:0] out_vel_x, out_vel_y, out_vel_z;
    logic               step_done;
    logic               psel = 0;
    logic               penable = 0;
    logic               pwrite = 0;
    logic [3:0]         paddr = 0;
    logic [31:0]        pwdata = 0;
    logic [31:0]        prdata;
    logic               pready;
    int                 fails;
    int                 pending;
    int                 cycles = 0;
    int                 burst_left = 0;
    int                 pos_mode = 0;
    logic               loaded [NBG_MAX_POINTS];

    logic [31:0] ph_g    [PHASES] = '{32'd65536, 32'd0, 32'hFFFF_FFFF, 32'd196608,
                                      32'd1048576, 32'd65536, 32'd200000, 32'd1};
    logic [31:0] ph_dist [PHASES] = '{32'd655, 32'd0, 32'd1000, 32'hFFFF_FFFF,
                                      32'd0, 32'd655, 32'd70000, 32'd0};
    logic [31:0] ph_mass [PHASES] = '{32'd65536, 32'd1, 32'hFFFF_FFFF, 32'd65536,
                                      32'd131072, 32'd30000, 32'd65536, 32'd1};
    int          ph_count[PHASES] = '{2, 5, 3, 64, 8, 4, 6, 2};
    int          ph_mode [PHASES] = '{1, 0, 1, 2, 1, 0, 1, 0};

    always #1 clk = ~clk;

    nbody_gravity_step uut (.*);

    nbody_gravity_step_checker monitor (
        .clk, .rst_n, .in_valid, .in_stall, .command, .point_index,
        .in_pos_x, .in_pos_y, .in_pos_z, .out_valid, .out_stall, .out_index,
        .out_pos_x, .out_pos_y, .out_pos_z, .out_vel_x, .out_vel_y, .out_vel_z,
        .step_done, .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .fails, .pending
    );

    task automatic reg_write(logic [1:0] which, logic [31:0] value);
        @(posedge clk);
        psel <= 1;
        penable <= 0;
        pwrite <= 1;
        paddr <= {which, 2'b00};
        pwdata <= value;
        @(posedge clk);
        penable <= 1;
        @(posedge clk);
        psel <= 0;
        penable <= 0;
        pwrite <= 0;
    endtask

    function automatic logic [31:0] coord();
        case (pos_mode)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 32'h0008_0000)) - 32'sh0004_0000);
            default: return 32'($signed($urandom_range(0, 32'h0000_8000)) - 32'sh0000_4000);
        endcase
    endfunction

    task automatic send_word(logic [1:0] cmd, logic [5:0] idx,
                             logic [31:0] x, logic [31:0] y, logic [31:0] z);
        if (burst_left == 0)
        begin
            in_valid <= 0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
            burst_left = $urandom_range(1, 20);
        end
        command <= cmd;
        point_index <= idx;
        in_pos_x <= x;
        in_pos_y <= y;
        in_pos_z <= z;
        in_valid <= 1;
        burst_left--;
        forever
        begin
            @(negedge clk);
            if (!in_stall)
            begin
                @(posedge clk);
                break;
            end
            @(posedge clk);
        end
        if (cmd == CMD_LOAD)
            loaded[idx] = 1;
    endtask

    task automatic settle();
        in_valid <= 0;
        burst_left = 0;
        @(posedge clk);
        wait (pending == 0);
        repeat (20) @(posedge clk);
    endtask

    task automatic directed_part();
        send_word(CMD_LOAD, 0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_word(CMD_LOAD, 1, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_word(CMD_READ, 0, $urandom, $urandom, $urandom);
        send_word(CMD_READ, 1, $urandom, $urandom, $urandom);
        send_word(CMD_STEP, 63, $urandom, $urandom, $urandom);
        send_word(CMD_READ, 0, 0, 0, 0);
        send_word(CMD_READ, 1, 0, 0, 0);
        send_word(2'd3, 63, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_word(CMD_LOAD, 63, 0, 0, 0);
        send_word(CMD_READ, 63, 0, 0, 0);
        send_word(CMD_LOAD, 0, 0, 0, 0);
        send_word(CMD_LOAD, 1, 0, 0, 0);
        send_word(CMD_STEP, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0);
        send_word(CMD_LOAD, 1, 32'h0001_0000, 0, 0);
        send_word(CMD_STEP, 0, 0, 0, 0);
        send_word(CMD_READ, 0, 0, 0, 0);
        send_word(CMD_READ, 1, 0, 0, 0);
        send_word(CMD_LOAD, 1, 32'h0000_0010, 32'h0000_0001, 0);
        send_word(CMD_STEP, 0, 0, 0, 0);
        send_word(CMD_READ, 1, 0, 0, 0);
    endtask

    task automatic random_phase(int count, int words, int step_weight);
        int pick;
        int idx;
        for (int i = 0; i < count; i++)
            send_word(CMD_LOAD, 6'(i), coord(), coord(), coord());
        for (int k = 0; k < words; k++)
        begin
            pick = $urandom_range(0, 999);
            if (pick < step_weight)
                send_word(CMD_STEP, 6'($urandom), $urandom, $urandom, $urandom);
            else if (pick < 470)
            begin
                idx = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 63)
                                                  : $urandom_range(0, count - 1);
                send_word(CMD_LOAD, 6'(idx), coord(), coord(), coord());
            end
            else if (pick < 960)
            begin
                do
                    idx = ($urandom_range(0, 1) == 0) ? $urandom_range(0, 63)
                                                      : $urandom_range(0, count - 1);
                while (!loaded[idx]);
                send_word(CMD_READ, 6'(idx), $urandom, $urandom, $urandom);
            end
            else
                send_word(2'd3, 6'($urandom), $urandom, $urandom, $urandom);
        end
    endtask

    initial
    begin
        foreach (loaded[i])
            loaded[i] = 0;
        repeat (3) @(posedge clk);
        rst_n <= 1;
        reg_write(REG_COUNT, 32'd2);
        pos_mode = 1;
        directed_part();
        for (int p = 0; p < PHASES; p++)
        begin
            settle();
            reg_write(REG_G_CONST, ph_g[p]);
            reg_write(REG_MIN_DIST, ph_dist[p]);
            reg_write(REG_MASS, ph_mass[p]);
            reg_write(REG_COUNT, 32'(ph_count[p]));
            pos_mode = ph_mode[p];
            random_phase(ph_count[p], 230, (ph_count[p] > 8) ? 8 : 25);
        end
        settle();
        repeat (100) @(posedge clk);
        if (fails == 0)
            $display("[nbody_gravity_step] OK");
        else
            $display("[nbody_gravity_step] ERROR");
        $finish;
    end

    initial
    begin
        int taken;
        int mode;
        taken = 0;
        forever
        begin
            mode = $urandom_range(0, 3);
            repeat ($urandom_range(20, 200))
            begin
                @(posedge clk);
                if (out_valid && !out_stall)
                    taken++;
                if (taken == 300)
                begin
                    taken++;
                    out_stall <= 1;
                    repeat (3000) @(posedge clk);
                end
                case (mode)
                    0: out_stall <= 0;
                    1: out_stall <= ($urandom_range(0, 9) < 3);
                    2: out_stall <= ~out_stall;
                    default: out_stall <= ($urandom_range(0, 9) < 7);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT)
        begin
            $display("[nbody_gravity_step] ERROR");
            $finish;
        end
    end

endmodule

>>> files.f
rtl/nbg_pkg.sv
rtl/nbg_ram.sv
rtl/nbg_div.sv
rtl/nbg_sqrt.sv
rtl/nbody_gravity_step.sv
dv/nbody_gravity_step_checker.sv
dv/nbody_gravity_step_test.sv
